// ===== hdl/smvlq_pkg.sv =====
// Shared constants and helpers for the source map VLQ segment decoder.
// Holds the character codes, the slot count and the base64 digit map.
// Depends on nothing.
`timescale 1ns / 1ps

package smvlq_pkg;

	localparam int LINE_BITS_DEFAULT = 24;
	localparam int GEN_LINE_BITS     = 24;
	localparam int VALUE_BITS        = 32;
	localparam int NUM_SLOTS         = 5;
	localparam int GROUP_BITS        = 5;

	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_SEMI  = 8'h3B;

	// Shift stops growing here, so an overlong group stays open.
	localparam logic [5:0] SHIFT_CAP  = 6'd35;
	localparam logic [5:0] SHIFT_STEP = 6'd5;

	localparam logic [VALUE_BITS-1:0] MOST_NEGATIVE = 32'h8000_0000;

	typedef logic [VALUE_BITS-1:0] value_t;

	// Digit value of a base64 character; '=' counts as digit 64.
	function automatic logic [6:0] digit_of(input logic [7:0] c);
		logic [6:0] d;
		d = '0;
		case (c) inside
			[8'h41:8'h5A]: d = 7'(c - 8'h41);
			[8'h61:8'h7A]: d = 7'(c - 8'h61 + 8'd26);
			[8'h30:8'h39]: d = 7'(c - 8'h30 + 8'd52);
			8'h2B:         d = 7'd62;
			8'h2F:         d = 7'd63;
			8'h3D:         d = 7'd64;
			default:       d = '0;
		endcase
		return d;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		logic ok;
		ok = 1'b0;
		case (c) inside
			[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], 8'h2B, 8'h2F, 8'h3D: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

endpackage

// ===== hdl/source_map_vlq_segment_decoder.sv =====
// Source map v3 mappings decoder: base64 VLQ digits in, finished segments out.
// Uses smvlq_pkg for the digit map, character codes and constants.
// An accepted word is decoded from the input register, and its segment word
// is then held in the result register until it leaves.
// Throughput: one character word per cycle while the result register is not held; the
// input register, one pass of decode and slot add, and the result register set that rate.
// Reset (arst_n low): all slots, line count and segment state clear at once.
`timescale 1ns / 1ps

module source_map_vlq_segment_decoder #(
	parameter int LINE_BITS = smvlq_pkg::LINE_BITS_DEFAULT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // [7:0] char_code
	input  logic         s_axis_tlast,  // end_of_text
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [23:0] gen_line, [55:24] gen_column, [87:56] source_index,
	// [119:88] source_line, [151:120] source_column
	output logic [151:0] m_axis_tdata
);

	// Input register stage. The character and the end flag sit here while the
	// segment state is updated from them.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// Segment state. The slots hold the running totals of the five fields,
	// of which the name index is kept but never reported.
	smvlq_pkg::value_t acc_q;
	logic [5:0]        shift_q;
	logic [2:0]        count_q;
	logic              invalid_q;
	smvlq_pkg::value_t slot_q [smvlq_pkg::NUM_SLOTS];
	logic [LINE_BITS-1:0] line_q;

	// The item in the input register is processed when the result register is
	// free or is being emptied in the same cycle.
	logic proc;
	assign proc = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Decode of the held character.
	logic       is_sep;
	logic       is_semi;
	logic       is_dig;
	logic [6:0] digit;
	assign is_semi = (char_s1 == smvlq_pkg::CHAR_SEMI);
	assign is_sep  = is_semi || (char_s1 == smvlq_pkg::CHAR_COMMA);
	assign is_dig  = smvlq_pkg::is_digit(char_s1);
	assign digit   = smvlq_pkg::digit_of(char_s1);

	// Group arithmetic: the payload lands at the current shift, dropping
	// anything at bit 32 or above. A finished value has its sign in bit 0;
	// a negative zero turns into the most negative number.
	smvlq_pkg::value_t acc_sum;
	smvlq_pkg::value_t mag;
	smvlq_pkg::value_t value;
	smvlq_pkg::value_t slot_sum;
	logic [5:0]        shift_next;
	logic              cont;
	logic              slot_free;
	logic              emit;

	always_comb begin
		acc_sum = acc_q;
		if (shift_q < 6'd32) begin
			acc_sum = acc_q + (smvlq_pkg::value_t'(digit[smvlq_pkg::GROUP_BITS-1:0])
				<< shift_q[4:0]);
		end
		cont       = digit[smvlq_pkg::GROUP_BITS];
		shift_next = (shift_q + smvlq_pkg::SHIFT_STEP > smvlq_pkg::SHIFT_CAP) ?
			smvlq_pkg::SHIFT_CAP : shift_q + smvlq_pkg::SHIFT_STEP;
		mag = {1'b0, acc_sum[smvlq_pkg::VALUE_BITS-1:1]};
		if (!acc_sum[0]) begin
			value = mag;
		end else if (mag == '0) begin
			value = smvlq_pkg::MOST_NEGATIVE;
		end else begin
			value = smvlq_pkg::value_t'(0) - mag;
		end
		slot_free = (count_q < 3'(smvlq_pkg::NUM_SLOTS));
		slot_sum  = slot_q[slot_free ? count_q : 3'd0] + value;
		// A segment goes out only when closed with no value half built and
		// one, four or five values in it.
		emit = !invalid_q && (shift_q == 6'd0) && (count_q inside {3'd1, 3'd4, 3'd5});
	end

	// Segment state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			shift_q   <= '0;
			count_q   <= '0;
			invalid_q <= 1'b0;
			line_q    <= '0;
			for (int i = 0; i < smvlq_pkg::NUM_SLOTS; i++) begin
				slot_q[i] <= '0;
			end
		end else if (proc) begin
			if (last_s1) begin
				// End of text closes the segment, then everything starts over.
				acc_q     <= '0;
				shift_q   <= '0;
				count_q   <= '0;
				invalid_q <= 1'b0;
				line_q    <= '0;
				for (int i = 0; i < smvlq_pkg::NUM_SLOTS; i++) begin
					slot_q[i] <= '0;
				end
			end else if (is_sep) begin
				acc_q     <= '0;
				shift_q   <= '0;
				count_q   <= '0;
				invalid_q <= 1'b0;
				if (is_semi) begin
					line_q    <= line_q + LINE_BITS'(1);
					slot_q[0] <= '0;
				end
			end else if (!invalid_q) begin
				if (!is_dig) begin
					invalid_q <= 1'b1;
				end else if (cont) begin
					acc_q   <= acc_sum;
					shift_q <= shift_next;
				end else begin
					acc_q   <= '0;
					shift_q <= '0;
					if (slot_free) begin
						slot_q[count_q] <= slot_sum;
						count_q         <= count_q + 3'd1;
					end else begin
						// A sixth value is thrown away and spoils the segment.
						invalid_q <= 1'b1;
					end
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (proc) begin
			m_axis_tvalid <= (last_s1 || is_sep) && emit;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && (last_s1 || is_sep) && emit) begin
			m_axis_tdata <= {slot_q[3], slot_q[2], slot_q[1], slot_q[0],
				smvlq_pkg::GEN_LINE_BITS'(line_q)};
		end
	end

	// A digit or stray byte never moves the line count.
	a_line_hold: assert property (@(posedge clk) disable iff (!arst_n)
		proc && !last_s1 && !is_sep |=> line_q == $past(line_q))
		else $error("line count moved on a non-separator word");

	// End of text leaves the decoder in its reset state.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		proc && last_s1 |=> line_q == '0 && count_q == 3'd0 && shift_q == 6'd0
			&& !invalid_q)
		else $error("end of text did not clear the decoder");

	// A semicolon restarts the generated column.
	a_semi_col: assert property (@(posedge clk) disable iff (!arst_n)
		proc && !last_s1 && is_semi |=> slot_q[0] == '0)
		else $error("column slot not cleared on new line");

	// No result appears from a word that does not close a segment.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		proc && !last_s1 && !is_sep && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result emitted without a separator");

endmodule
